@@ hw/rtl/hsi_pkg.sv @@
// Shared types, widths and codes of the hash set intersection engine.
package hsi_pkg;

   localparam int unsigned DEFAULT_TABLE_DEPTH = 64;
   localparam int unsigned KEY_W   = 32;
   localparam int unsigned REQ_W   = 2;
   localparam int unsigned COUNT_W = 7;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_PROBE  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

   localparam logic STATUS_COMMON = 1'b0;
   localparam logic STATUS_FULL   = 1'b1;

   // One table slot as kept in the memory.
   typedef struct packed {
      logic             occupied;
      logic             emitted;
      logic [KEY_W-1:0] key;
   } entry_type;

endpackage

@@ hw/rtl/hsi_if.sv @@
// Request and response channel interfaces of the hash set intersection engine.
interface hsi_req_if;
   import hsi_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [REQ_W-1:0]        req_type;
   logic signed [KEY_W-1:0] value;
   modport source (output valid, req_type, value, input ready);
   modport sink   (input valid, req_type, value, output ready);
endinterface

interface hsi_rsp_if;
   import hsi_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    status;
   logic signed [KEY_W-1:0] common_value;
   logic [COUNT_W-1:0]      common_count;
   modport source (output valid, status, common_value, common_count, input ready);
   modport sink   (input valid, status, common_value, common_count, output ready);
endinterface

@@ hw/rtl/hsi_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module hsi_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ hw/rtl/hash_set_intersection.sv @@
// Hash set intersection engine: keys, occupied and emitted flags share one table memory.
//
// Insert items store values in a table of TABLE_DEPTH slots, probe items look them up and
// report each common value once, and clear items empty the table; an insert that finds
// neither its key nor a free slot reports a full status. One item is in work at a time.
// An item is accepted, then every slot it visits takes an address step and a step for the
// registered memory read and write-back; a result then goes on to the output register.
// When TABLE_DEPTH is not a power of two, the home slot comes from a remainder unit that
// runs before the first slot is visited. After reset, and after every clear item, a
// clearing pass writes every slot, one per cycle, before the next item is taken. A finished
// result waits in the output register while the next item runs.
module hash_set_intersection #(
   parameter int unsigned TABLE_DEPTH = hsi_pkg::DEFAULT_TABLE_DEPTH
) (
   input logic      clock,
   input logic      reset,
   hsi_req_if.sink  req_ch,
   hsi_rsp_if.source rsp_ch
);
   import hsi_pkg::*;

   localparam int unsigned IdxW      = $clog2(TABLE_DEPTH);
   localparam int unsigned RemW      = IdxW + 1;
   localparam int unsigned VisitW    = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned DigitBits = 4;
   localparam int unsigned DivSteps  = KEY_W / DigitBits;
   localparam int unsigned DivCntW   = $clog2(DivSteps);
   localparam bit          IsPow2    = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
   localparam int unsigned EntryW    = $bits(entry_type);

   typedef enum logic [5:0] {
      ST_CLEAR    = 6'b000001,
      ST_IDLE     = 6'b000010,
      ST_DIVIDE   = 6'b000100,
      ST_ISSUE    = 6'b001000,
      ST_CHECK    = 6'b010000,
      ST_WAIT_OUT = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [REQ_W-1:0]    type_ff, type_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [KEY_W-1:0]    mag_ff, mag_in;
   logic [RemW-1:0]     rem_ff, rem_in;
   logic [DivCntW-1:0]  div_ff, div_in;
   logic [IdxW-1:0]     idx_ff, idx_in;
   logic [VisitW-1:0]   visit_ff, visit_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                pend_status_ff, pend_status_in;
   logic [KEY_W-1:0]    pend_value_ff, pend_value_in;
   logic [COUNT_W-1:0]  pend_count_ff, pend_count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                req_fire;
   logic                rsp_free;
   logic                rsp_load;
   logic [KEY_W-1:0]    req_mag;
   logic [RemW-1:0]     rem_step;
   logic [IdxW-1:0]     idx_wrap;
   logic                last_slot;
   logic                key_hit;
   logic [COUNT_W-1:0]  count_inc;
   logic                mem_we;
   entry_type           mem_wdata;
   entry_type           mem_rdata;

   hsi_ram #(
      .WIDTH (EntryW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (mem_we),
      .waddr (idx_ff),
      .wdata (mem_wdata),
      .raddr (idx_ff),
      .rdata (mem_rdata)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_load     = (state_ff == ST_WAIT_OUT) && rsp_free;

   // The magnitude of the most negative value is its own bit pattern, read unsigned.
   assign req_mag   = req_ch.value[KEY_W-1] ? (KEY_W'(0) - KEY_W'(req_ch.value))
                                            : KEY_W'(req_ch.value);
   assign idx_wrap  = (idx_ff == IdxW'(TABLE_DEPTH - 1)) ? '0 : idx_ff + 1'b1;
   assign last_slot = (visit_ff == VisitW'(TABLE_DEPTH - 1));
   assign key_hit   = (mem_rdata.key == key_ff);
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;

   // Restoring remainder, one digit of the magnitude per cycle.
   always_comb begin
      logic [RemW-1:0] r;
      r = rem_ff;
      for (int j = 0; j < DigitBits; j++) begin
         r = {r[RemW-2:0], mag_ff[KEY_W-1-j]};
         if (r >= RemW'(TABLE_DEPTH)) begin
            r = r - RemW'(TABLE_DEPTH);
         end
      end
      rem_step = r;
   end

   always_comb begin
      state_in       = state_ff;
      type_in        = type_ff;
      key_in         = key_ff;
      mag_in         = mag_ff;
      rem_in         = rem_ff;
      div_in         = div_ff;
      idx_in         = idx_ff;
      visit_in       = visit_ff;
      count_in       = count_ff;
      pend_status_in = pend_status_ff;
      pend_value_in  = pend_value_ff;
      pend_count_in  = pend_count_ff;
      mem_we         = 1'b0;
      mem_wdata      = '{occupied: 1'b0, emitted: 1'b0, key: key_ff};

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            count_in = '0;
            idx_in   = idx_wrap;
            if (idx_ff == IdxW'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               type_in  = req_ch.req_type;
               key_in   = KEY_W'(req_ch.value);
               mag_in   = req_mag;
               rem_in   = '0;
               div_in   = '0;
               visit_in = '0;
               idx_in   = req_mag[IdxW-1:0];
               if (req_ch.req_type == REQ_CLEAR) begin
                  idx_in   = '0;
                  state_in = ST_CLEAR;
               end else if (req_ch.req_type == REQ_INSERT ||
                            req_ch.req_type == REQ_PROBE) begin
                  state_in = IsPow2 ? ST_ISSUE : ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            rem_in = rem_step;
            mag_in = mag_ff << DigitBits;
            div_in = div_ff + 1'b1;
            if (div_ff == DivCntW'(DivSteps - 1)) begin
               idx_in   = rem_step[IdxW-1:0];
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = ST_IDLE;
            if (type_ff == REQ_INSERT) begin
               if (!mem_rdata.occupied) begin
                  mem_we    = 1'b1;
                  mem_wdata = '{occupied: 1'b1, emitted: 1'b0, key: key_ff};
               end else if (!key_hit) begin
                  if (last_slot) begin
                     pend_status_in = STATUS_FULL;
                     pend_value_in  = '0;
                     pend_count_in  = count_ff;
                     state_in       = ST_WAIT_OUT;
                  end else begin
                     idx_in   = idx_wrap;
                     visit_in = visit_ff + 1'b1;
                     state_in = ST_ISSUE;
                  end
               end
            end else begin
               if (mem_rdata.occupied && key_hit) begin
                  if (!mem_rdata.emitted) begin
                     mem_we         = 1'b1;
                     mem_wdata      = '{occupied: 1'b1, emitted: 1'b1, key: key_ff};
                     count_in       = count_inc;
                     pend_status_in = STATUS_COMMON;
                     pend_value_in  = key_ff;
                     pend_count_in  = count_inc;
                     state_in       = ST_WAIT_OUT;
                  end
               end else if (mem_rdata.occupied && !last_slot) begin
                  idx_in   = idx_wrap;
                  visit_in = visit_ff + 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_WAIT_OUT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_status_ff;
         rsp_value_in  = pend_value_ff;
         rsp_count_in  = pend_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff        <= type_in;
      key_ff         <= key_in;
      mag_ff         <= mag_in;
      rem_ff         <= rem_in;
      div_ff         <= div_in;
      visit_ff       <= visit_in;
      pend_status_ff <= pend_status_in;
      pend_value_ff  <= pend_value_in;
      pend_count_ff  <= pend_count_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.common_value = rsp_value_ff;
   assign rsp_ch.common_count = rsp_count_ff;

   // A clear item always starts a clearing pass.
   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.req_type == REQ_CLEAR) |=> state_ff == ST_CLEAR)
      else $error("clear item did not start a clearing pass");

   // The table is written only by the clearing pass or a slot check.
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_CHECK))
      else $error("table written outside a clearing pass or slot check");

   // A common element always carries a nonzero running count.
   a_common_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_COMMON) |-> rsp_count_ff != '0)
      else $error("common element reported with a zero count");

   // A probe sequence never walks past the whole table.
   a_visit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> visit_ff < VisitW'(TABLE_DEPTH))
      else $error("probe sequence visited more slots than the table holds");

endmodule

@@ tb/tb_hash_set_intersection.sv @@
// Self-checking testbench for the hash set intersection engine with a built-in table predictor.
`timescale 1ns / 100ps

module tb_hash_set_intersection;
   import hsi_pkg::*;

   localparam int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int unsigned TARGET_ITEMS = 570;
   localparam int unsigned IDLE_LIMIT = 4000;
   localparam int unsigned DRAIN_CYCLES = 400;
   localparam int unsigned RX_HOLD_CYCLES = 400;

   typedef struct {
      logic [REQ_W-1:0]        kind;
      logic signed [KEY_W-1:0] value;
      bit                      wait_empty;
   } set_op_type;

   typedef struct packed {
      logic                    status;
      logic signed [KEY_W-1:0] value;
      logic [COUNT_W-1:0]      count;
   } common_result_type;

   typedef enum int unsigned {VAL_ANY, VAL_NARROW, VAL_CLUSTER, VAL_EDGE} value_style_type;
   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_pattern_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic [REQ_W-1:0]        req_kind  = REQ_INSERT;
   logic signed [KEY_W-1:0] req_value = '0;
   logic                    rsp_ready = 1'b0;

   hsi_req_if req_ch ();
   hsi_rsp_if rsp_ch ();

   assign req_ch.valid    = req_valid;
   assign req_ch.req_type = req_kind;
   assign req_ch.value    = req_value;
   assign rsp_ch.ready    = rsp_ready;

   hash_set_intersection #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   set_op_type        op_queue[$];
   common_result_type expected_commons[$];
   int unsigned       ops_queued = 0;
   int unsigned       check_errors = 0;

   // Predicted copy of the table.
   logic [KEY_W-1:0]   tbl_keys [TABLE_DEPTH];
   bit                 tbl_used [TABLE_DEPTH];
   bit                 tbl_emitted [TABLE_DEPTH];
   logic [COUNT_W-1:0] found_total = '0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned home_slot(logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] mag;
      mag = key[KEY_W-1] ? (32'd0 - key) : key;
      return mag % TABLE_DEPTH;
   endfunction

   task automatic wipe_table();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tbl_used[i] = 1'b0;
         tbl_emitted[i] = 1'b0;
      end
      found_total = '0;
   endtask

   // Applies one accepted item to the predicted table and queues any result it causes.
   task automatic intersect_step(logic [REQ_W-1:0] kind, logic [KEY_W-1:0] key);
      int unsigned       start;
      int unsigned       slot;
      common_result_type r;
      start = home_slot(key);
      case (kind)
         REQ_CLEAR: wipe_table();
         REQ_INSERT: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               slot = (start + i) % TABLE_DEPTH;
               if (!tbl_used[slot]) begin
                  tbl_used[slot] = 1'b1;
                  tbl_emitted[slot] = 1'b0;
                  tbl_keys[slot] = key;
                  return;
               end
               if (tbl_keys[slot] == key) return;
            end
            r.status = STATUS_FULL;
            r.value = '0;
            r.count = found_total;
            expected_commons.push_back(r);
         end
         REQ_PROBE: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               slot = (start + i) % TABLE_DEPTH;
               if (!tbl_used[slot]) return;
               if (tbl_keys[slot] == key) begin
                  if (tbl_emitted[slot]) return;
                  tbl_emitted[slot] = 1'b1;
                  if (found_total < COUNT_MAX) found_total = found_total + 1'b1;
                  r.status = STATUS_COMMON;
                  r.value = key;
                  r.count = found_total;
                  expected_commons.push_back(r);
                  return;
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic queue_op(logic [REQ_W-1:0] kind, logic [KEY_W-1:0] value, bit wait_empty);
      set_op_type op;
      op.kind = kind;
      op.value = value;
      op.wait_empty = wait_empty;
      op_queue.push_back(op);
      ops_queued++;
   endtask

   function automatic logic [KEY_W-1:0] draw_value(value_style_type style);
      logic [KEY_W-1:0] v;
      case (style)
         VAL_NARROW: v = 32'($urandom_range(0, 200)) - 32'd100;
         VAL_CLUSTER: begin
            // Few home slots, many keys per slot, both signs.
            v = 32'($urandom_range(0, 3)) + 32'(TABLE_DEPTH) * 32'($urandom_range(0, 40));
            if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
         end
         VAL_EDGE: begin
            case ($urandom_range(0, 5))
               0: v = 32'h8000_0000;
               1: v = 32'h7fff_ffff;
               2: v = 32'h0000_0000;
               3: v = 32'hffff_ffff;
               4: v = 32'h8000_0000 + 32'($urandom_range(1, 300));
               default: v = $urandom;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // One episode: clear, a run of inserts, then mostly probes of the stored keys.
   task automatic queue_episode(bit fill_up, bit wait_first);
      logic [KEY_W-1:0] keys[$];
      logic [KEY_W-1:0] v;
      value_style_type  style;
      int unsigned      n_ins;
      int unsigned      n_probe;
      int unsigned      pick;
      style = fill_up ? VAL_ANY : value_style_type'($urandom_range(0, 3));
      queue_op(REQ_CLEAR, $urandom, wait_first);
      n_ins = fill_up ? TABLE_DEPTH + 16 : $urandom_range(1, 30);
      for (int i = 0; i < n_ins; i++) begin
         if (keys.size() != 0 && $urandom_range(0, 9) == 0) begin
            v = keys[$urandom_range(0, keys.size() - 1)];
         end else begin
            v = draw_value(style);
            keys.push_back(v);
         end
         queue_op(REQ_INSERT, v, 1'b0);
         if ($urandom_range(0, 19) == 0) queue_op(REQ_UNUSED, $urandom, 1'b0);
      end
      n_probe = $urandom_range(n_ins / 2, n_ins + 10);
      for (int i = 0; i < n_probe; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            queue_op(REQ_PROBE, keys[$urandom_range(0, keys.size() - 1)], 1'b0);
         end else if (pick < 85) begin
            queue_op(REQ_PROBE, draw_value(style), 1'b0);
         end else if (pick < 93) begin
            v = draw_value(style);
            keys.push_back(v);
            queue_op(REQ_INSERT, v, 1'b0);
         end else begin
            queue_op(REQ_UNUSED, $urandom, 1'b0);
         end
      end
   endtask

   initial begin
      // Directed part: extremes, collisions on slot zero, duplicates and the count reset.
      queue_op(REQ_PROBE, 32'd0, 1'b0);
      queue_op(REQ_INSERT, 32'd0, 1'b0);
      queue_op(REQ_INSERT, 32'h7fff_ffff, 1'b0);
      queue_op(REQ_INSERT, 32'h8000_0000, 1'b0);
      queue_op(REQ_INSERT, 32'hffff_ffff, 1'b0);
      queue_op(REQ_INSERT, 32'd64, 1'b0);
      queue_op(REQ_INSERT, -32'sd64, 1'b0);
      queue_op(REQ_INSERT, 32'd0, 1'b0);
      queue_op(REQ_UNUSED, 32'h5a5a_5a5a, 1'b0);
      queue_op(REQ_PROBE, 32'h8000_0000, 1'b0);
      queue_op(REQ_PROBE, -32'sd64, 1'b0);
      queue_op(REQ_PROBE, 32'h7fff_ffff, 1'b0);
      queue_op(REQ_PROBE, 32'd0, 1'b0);
      queue_op(REQ_PROBE, 32'd0, 1'b0);
      queue_op(REQ_PROBE, 32'd128, 1'b0);
      queue_op(REQ_PROBE, 32'hffff_ffff, 1'b0);
      queue_op(REQ_PROBE, 32'd1, 1'b0);
      queue_op(REQ_CLEAR, 32'ha5a5_a5a5, 1'b1);
      queue_op(REQ_PROBE, 32'd0, 1'b0);
      queue_op(REQ_INSERT, 32'd5, 1'b0);
      queue_op(REQ_PROBE, 32'd5, 1'b0);

      // The first random episode queues more inserts than the table has slots, to overflow it.
      queue_episode(1'b1, 1'b1);
      while (ops_queued < TARGET_ITEMS) begin
         queue_episode($urandom_range(0, 7) == 0, $urandom_range(0, 2) == 0);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (op_queue.size() != 0 || expected_commons.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (check_errors == 0) begin
         $display("tb_hash_set_intersection: done, clean");
      end else begin
         $display("tb_hash_set_intersection: done, errors");
      end
      $finish;
   end

   // Sender: bursts of random length separated by random gaps.
   int unsigned burst_left = 1;
   int unsigned gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ch.ready) op_queue.delete(0);
         if (!req_valid || req_ch.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (op_queue.size() == 0 ||
                         (op_queue[0].wait_empty &&
                          (expected_commons.size() != 0 || (req_valid && req_ch.ready)))) begin
               // An item accepted at this edge may still add an expected result.
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_kind <= op_queue[0].kind;
               req_value <= op_queue[0].value;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // Receiver: a rotating stall pattern, with two long hold-offs that back the block up.
   logic [31:0] rx_cycle = '0;
   int unsigned rx_taken = 0;
   int unsigned rx_hold = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_ready && rsp_ch.valid) rx_taken++;
         if (rx_hold != 0) begin
            rx_hold--;
            rsp_ready <= 1'b0;
         end else if (rsp_ready && rsp_ch.valid && (rx_taken == 60 || rx_taken == 300)) begin
            rx_hold = RX_HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rx_cycle = rx_cycle + 1;
            case (rx_pattern_type'(rx_cycle[9:8]))
               RX_OPEN:     rsp_ready <= 1'b1;
               RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
               RX_PERIODIC: rsp_ready <= (rx_cycle[2:0] != 3'd5 && rx_cycle[2:0] != 3'd6);
               default:     rsp_ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // Monitor: predicts on every accepted request and checks every accepted result.
   always @(posedge clock) begin : monitor
      common_result_type want;
      if (reset) begin
         wipe_table();
      end else begin
         if (req_ch.valid && req_ch.ready) intersect_step(req_ch.req_type, req_ch.value);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_commons.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, got %0b %0d %0d",
                        $time, rsp_ch.status, rsp_ch.common_value, rsp_ch.common_count);
               check_errors++;
            end else begin
               want = expected_commons.pop_front();
               if (rsp_ch.status !== want.status) begin
                  $display("%0t ns: status mismatch, expected %0b, got %0b",
                           $time, want.status, rsp_ch.status);
                  check_errors++;
               end
               if (rsp_ch.common_value !== want.value) begin
                  $display("%0t ns: common_value mismatch, expected %0d, got %0d",
                           $time, want.value, rsp_ch.common_value);
                  check_errors++;
               end
               if (rsp_ch.common_count !== want.count) begin
                  $display("%0t ns: common_count mismatch, expected %0d, got %0d",
                           $time, want.count, rsp_ch.common_count);
                  check_errors++;
               end
            end
         end
      end
   end

   // Watchdog: ends the run when neither channel moves an item for too long.
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: timeout, %0d results still expected", $time, expected_commons.size());
         $display("tb_hash_set_intersection: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
